/* rtl/readiness_edge_report_table_top_defines.svh */
// Assertion macros for the checker file of the readiness table.
`ifndef READINESS_EDGE_REPORT_TABLE_TOP_DEFINES_SVH
`define READINESS_EDGE_REPORT_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RETS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RETS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rets_pkg.sv */
// Package with widths, event bits, codes and the slot entry type of the readiness table.
package rets_pkg;

   localparam int WATCH_SLOTS = 64;
   localparam int IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
   localparam int OP_W = 3;
   localparam int SLOT_W = 6;
   localparam int MASK_W = 32;
   localparam int SEQ_W = 64;
   localparam int STATUS_W = 2;

   localparam logic [MASK_W-1:0] EV_IN = 32'h0000_0001;
   localparam logic [MASK_W-1:0] EV_PRI = 32'h0000_0002;
   localparam logic [MASK_W-1:0] EV_OUT = 32'h0000_0004;
   localparam logic [MASK_W-1:0] EV_ERR = 32'h0000_0008;
   localparam logic [MASK_W-1:0] EV_HUP = 32'h0000_0010;
   localparam logic [MASK_W-1:0] EV_RDNORM = 32'h0000_0040;
   localparam logic [MASK_W-1:0] EV_RDBAND = 32'h0000_0080;
   localparam logic [MASK_W-1:0] EV_WRNORM = 32'h0000_0100;
   localparam logic [MASK_W-1:0] EV_WRBAND = 32'h0000_0200;
   localparam logic [MASK_W-1:0] EV_RDHUP = 32'h0000_2000;
   localparam logic [MASK_W-1:0] EV_ONESHOT = 32'h4000_0000;
   localparam logic [MASK_W-1:0] EV_ET = 32'h8000_0000;
   localparam logic [MASK_W-1:0] READ_GROUP =
      EV_IN | EV_PRI | EV_RDNORM | EV_RDBAND | EV_RDHUP | EV_ERR | EV_HUP;
   localparam logic [MASK_W-1:0] WRITE_GROUP =
      EV_OUT | EV_WRNORM | EV_WRBAND | EV_ERR | EV_HUP;

   typedef enum logic [OP_W-1:0] {
      OP_ARM = 3'd0,
      OP_REMOVE = 3'd1,
      OP_PREVIEW = 3'd2,
      OP_CLAIM = 3'd3,
      OP_FINISH = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 2'd0,
      STATUS_UNUSED = 2'd1,
      STATUS_TAG_MISMATCH = 2'd2,
      STATUS_BAD_OP = 2'd3
   } status_type;

   typedef struct packed {
      logic [MASK_W-1:0] interest;
      logic oneshot_off;
      logic [MASK_W-1:0] seen_ready;
      logic [SEQ_W-1:0] seen_read_seq;
      logic [SEQ_W-1:0] seen_write_seq;
      logic [MASK_W-1:0] delivered_bits;
      logic [SEQ_W-1:0] delivered_read_seq;
      logic [SEQ_W-1:0] delivered_write_seq;
      logic [SEQ_W-1:0] pending_claim;
   } watch_entry_type;

   // Counters step by one and skip zero on wrap.
   function automatic logic [SEQ_W-1:0] bump_nonzero(input logic [SEQ_W-1:0] value);
      logic [SEQ_W-1:0] sum;
      sum = value + {{(SEQ_W-1){1'b0}}, 1'b1};
      return (sum == '0) ? {{(SEQ_W-1){1'b0}}, 1'b1} : sum;
   endfunction

endpackage

/* rtl/rets_req_if.sv */
// Request channel interface of the readiness table: valid, ready and the item fields.
interface rets_req_if import rets_pkg::*; ();
   logic valid;
   logic ready;
   logic [OP_W-1:0] op;
   logic [SLOT_W-1:0] slot;
   logic [MASK_W-1:0] interest;
   logic [MASK_W-1:0] ready_mask;
   logic [SEQ_W-1:0] read_seq;
   logic [SEQ_W-1:0] write_seq;
   logic [SEQ_W-1:0] claim_tag_in;
   logic copy_ok;

   modport source (
      output valid, op, slot, interest, ready_mask, read_seq, write_seq, claim_tag_in,
         copy_ok,
      input ready
   );
   modport sink (
      input valid, op, slot, interest, ready_mask, read_seq, write_seq, claim_tag_in,
         copy_ok,
      output ready
   );
endinterface

/* rtl/rets_rsp_if.sv */
// Response channel interface of the readiness table: valid, ready and the result fields.
interface rets_rsp_if import rets_pkg::*; ();
   logic valid;
   logic ready;
   logic [MASK_W-1:0] report;
   logic [SEQ_W-1:0] claim_tag_out;
   logic ready_changed;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, report, claim_tag_out, ready_changed, status,
      input ready
   );
   modport sink (
      input valid, report, claim_tag_out, ready_changed, status,
      output ready
   );
endinterface

/* rtl/readiness_edge_report_table_top.sv */
// Readiness table with edge and level reporting: slot memory, counters and the one-pass update.
//
// Usage: each request transaction on req_if carries an operation (arm, remove, preview,
// claim, finish) for one watch slot; each produces exactly one response transaction on
// rsp_if with the report bits, a claim tag, the readiness-change flag and a status code.
// Responses come back in request order.
// Flow: an accepted request is registered in the compute stage and its response is then
// loaded into the output register, which drives rsp_if until the response is taken.
// Throughput: one transaction per cycle while rsp_if.ready stays high. The slot memory
// read is registered at acceptance, and a write from the transaction just ahead is
// forwarded, so back-to-back requests to the same slot see up-to-date state.
// Stalls: while the response waits, the request in the compute stage holds and req_if.ready
// drops only when both the output register and the compute stage are full.
// Reset: all slots become unused, the claim counter goes to zero and the readiness counter
// to one. Slot contents are written by arm before any use, so there is no clearing pass and
// requests are taken from the first cycle after reset.
module readiness_edge_report_table_top import rets_pkg::*; (
   input logic clock,
   input logic reset,
   rets_req_if.sink req_if,
   rets_rsp_if.source rsp_if
);

   // Compute stage registers.
   logic s1_valid_ff;
   logic [OP_W-1:0] s1_op_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [MASK_W-1:0] s1_interest_ff;
   logic [MASK_W-1:0] s1_ready_ff;
   logic [SEQ_W-1:0] s1_read_seq_ff;
   logic [SEQ_W-1:0] s1_write_seq_ff;
   logic [SEQ_W-1:0] s1_tag_ff;
   logic s1_copy_ok_ff;

   // Slot storage.
   watch_entry_type watch_mem [WATCH_SLOTS];
   watch_entry_type mem_rd_ff;
   watch_entry_type byp_data_ff;
   logic byp_hit_ff;
   logic [WATCH_SLOTS-1:0] slot_used_ff;
   logic [SEQ_W-1:0] claim_counter_ff;
   logic [SEQ_W-1:0] readiness_counter_ff;

   // Output register.
   logic rsp_valid_ff;
   logic [MASK_W-1:0] report_ff;
   logic [SEQ_W-1:0] tag_out_ff;
   logic changed_ff;
   logic [STATUS_W-1:0] status_ff;

   logic accept;
   logic s1_advance;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] s1_idx;
   logic s1_in_range;
   logic s1_used;
   watch_entry_type entry;
   watch_entry_type entry_in;
   logic mem_wr_en;
   logic used_set;
   logic used_clr;
   logic [MASK_W-1:0] report_in;
   logic [SEQ_W-1:0] tag_out_in;
   logic changed_in;
   status_type status_in;
   logic [SEQ_W-1:0] claim_counter_in;
   logic [SEQ_W-1:0] readiness_counter_in;

   logic [MASK_W-1:0] rep;
   logic rd_hit;
   logic wr_hit;
   logic fresh;
   logic [MASK_W-1:0] edge_bits;
   logic [MASK_W-1:0] selected;
   logic claim_takes;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign accept = req_if.valid && req_if.ready;

   assign req_idx = IDX_W'(req_if.slot);
   assign s1_idx = IDX_W'(s1_slot_ff);
   assign s1_in_range = int'(s1_slot_ff) < WATCH_SLOTS;
   assign s1_used = s1_in_range && slot_used_ff[s1_idx];

   // A write from the transaction ahead lands in the same edge as this read; take it over.
   assign entry = byp_hit_ff ? byp_data_ff : mem_rd_ff;

   // Readiness observation and report selection.
   assign rep = s1_ready_ff & (entry.interest | EV_ERR | EV_HUP);
   assign rd_hit = |(rep & READ_GROUP);
   assign wr_hit = |(rep & WRITE_GROUP);
   assign fresh = (rep != '0) &&
      (((rep & ~entry.seen_ready) != '0) ||
       (rd_hit && s1_read_seq_ff != '0 && s1_read_seq_ff != entry.seen_read_seq) ||
       (wr_hit && s1_write_seq_ff != '0 && s1_write_seq_ff != entry.seen_write_seq));
   assign edge_bits = (rep & ~entry.delivered_bits) |
      ((rd_hit && s1_read_seq_ff != '0 && s1_read_seq_ff != entry.delivered_read_seq) ?
         (rep & READ_GROUP) : '0) |
      ((wr_hit && s1_write_seq_ff != '0 && s1_write_seq_ff != entry.delivered_write_seq) ?
         (rep & WRITE_GROUP) : '0);
   assign selected = (rep == '0 || entry.pending_claim != '0) ? '0 :
      (((entry.interest & EV_ET) == '0) ? rep : edge_bits);
   assign claim_takes = (selected != '0) && ((entry.interest & (EV_ET | EV_ONESHOT)) != '0);

   always_comb begin
      entry_in = entry;
      mem_wr_en = 1'b0;
      used_set = 1'b0;
      used_clr = 1'b0;
      report_in = '0;
      tag_out_in = '0;
      changed_in = 1'b0;
      status_in = STATUS_OK;
      claim_counter_in = claim_counter_ff;
      readiness_counter_in = readiness_counter_ff;
      case (op_type'(s1_op_ff))
         OP_ARM: begin
            if (!s1_in_range) begin
               status_in = STATUS_UNUSED;
            end else begin
               entry_in = '0;
               entry_in.interest = s1_interest_ff;
               mem_wr_en = 1'b1;
               used_set = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!s1_used) begin
               status_in = STATUS_UNUSED;
            end else begin
               used_clr = 1'b1;
            end
         end
         OP_PREVIEW, OP_CLAIM: begin
            if (!s1_used) begin
               status_in = STATUS_UNUSED;
            end else if (!entry.oneshot_off) begin
               mem_wr_en = 1'b1;
               entry_in.seen_ready = rep;
               if (rd_hit) begin
                  entry_in.seen_read_seq = s1_read_seq_ff;
               end
               if (wr_hit) begin
                  entry_in.seen_write_seq = s1_write_seq_ff;
               end
               if (rep == '0) begin
                  entry_in.delivered_bits = '0;
                  entry_in.delivered_read_seq = '0;
                  entry_in.delivered_write_seq = '0;
                  entry_in.seen_read_seq = '0;
                  entry_in.seen_write_seq = '0;
               end
               changed_in = fresh;
               if (fresh) begin
                  readiness_counter_in = bump_nonzero(readiness_counter_ff);
               end
               report_in = selected;
               if (op_type'(s1_op_ff) == OP_CLAIM && claim_takes) begin
                  claim_counter_in = bump_nonzero(claim_counter_ff);
                  entry_in.pending_claim = claim_counter_in;
                  tag_out_in = claim_counter_in;
               end
            end
         end
         OP_FINISH: begin
            if (!s1_used) begin
               status_in = STATUS_UNUSED;
            end else if (s1_tag_ff == '0 || s1_tag_ff != entry.pending_claim) begin
               status_in = STATUS_TAG_MISMATCH;
            end else begin
               mem_wr_en = 1'b1;
               if (s1_copy_ok_ff) begin
                  if ((entry.interest & EV_ET) != '0) begin
                     entry_in.delivered_bits = entry.delivered_bits | s1_ready_ff;
                     if ((s1_ready_ff & READ_GROUP) != '0) begin
                        entry_in.delivered_read_seq = s1_read_seq_ff;
                     end
                     if ((s1_ready_ff & WRITE_GROUP) != '0) begin
                        entry_in.delivered_write_seq = s1_write_seq_ff;
                     end
                  end
                  if ((entry.interest & EV_ONESHOT) != '0) begin
                     entry_in.oneshot_off = 1'b1;
                  end
               end
               entry_in.pending_claim = '0;
            end
         end
         default: begin
            status_in = STATUS_BAD_OP;
         end
      endcase
   end

   // Request capture into the compute stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= req_if.op;
         s1_slot_ff <= req_if.slot;
         s1_interest_ff <= req_if.interest;
         s1_ready_ff <= req_if.ready_mask;
         s1_read_seq_ff <= req_if.read_seq;
         s1_write_seq_ff <= req_if.write_seq;
         s1_tag_ff <= req_if.claim_tag_in;
         s1_copy_ok_ff <= req_if.copy_ok;
      end
   end

   // Slot memory: one write port from the compute stage, one registered read port.
   always_ff @(posedge clock) begin
      if (s1_advance && mem_wr_en) begin
         watch_mem[s1_idx] <= entry_in;
      end
      if (accept) begin
         mem_rd_ff <= watch_mem[req_idx];
         byp_hit_ff <= s1_advance && mem_wr_en && (s1_idx == req_idx);
         byp_data_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         claim_counter_ff <= '0;
         readiness_counter_ff <= {{(SEQ_W-1){1'b0}}, 1'b1};
      end else if (s1_advance) begin
         if (used_set) begin
            slot_used_ff[s1_idx] <= 1'b1;
         end else if (used_clr) begin
            slot_used_ff[s1_idx] <= 1'b0;
         end
         claim_counter_ff <= claim_counter_in;
         readiness_counter_ff <= readiness_counter_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         report_ff <= report_in;
         tag_out_ff <= tag_out_in;
         changed_ff <= changed_in;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.report = report_ff;
   assign rsp_if.claim_tag_out = tag_out_ff;
   assign rsp_if.ready_changed = changed_ff;
   assign rsp_if.status = status_ff;

endmodule

/* rtl/rets_checker.sv */
// Port-level checker for the readiness table and its bind to the top level.
`include "readiness_edge_report_table_top_defines.svh"

module rets_checker import rets_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [MASK_W-1:0] report,
   input logic [SEQ_W-1:0] claim_tag_out,
   input logic ready_changed,
   input logic [STATUS_W-1:0] status
);

   `RETS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(report) && $stable(claim_tag_out) && $stable(status), "response changed while stalled")

   // Any failing status leaves every other result field clear.
   `RETS_ASSERT_SAME(a_fail_quiet, clock, reset, rsp_valid && status != STATUS_OK, report == '0 && claim_tag_out == '0 && !ready_changed, "failing status with nonzero fields")

   // A claim tag is only handed out together with something to deliver.
   `RETS_ASSERT_SAME(a_tag_has_report, clock, reset, rsp_valid && claim_tag_out != '0, report != '0 && status == STATUS_OK, "claim tag without report")

   `RETS_ASSERT_SAME(a_change_ok, clock, reset, rsp_valid && ready_changed, status == STATUS_OK, "readiness change on failing transaction")

endmodule

bind readiness_edge_report_table_top rets_checker u_rets_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .report(rsp_if.report),
   .claim_tag_out(rsp_if.claim_tag_out),
   .ready_changed(rsp_if.ready_changed),
   .status(rsp_if.status)
);

/* test/readiness_edge_report_table_top_tb.sv */
// Self-checking testbench for the readiness table: directed and random slot traffic.
`timescale 1ns / 100ps

module readiness_edge_report_table_top_tb import rets_pkg::*; ();

   localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
   localparam logic [MASK_W-1:0] EVENT_BITS = READ_GROUP | WRITE_GROUP;
   localparam int PLAN = 0;
   localparam int CHECK = 1;
   localparam int RANDOM_ITEMS = 1500;
   localparam int QUIET_TAIL = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [SLOT_W-1:0] slot;
      logic [MASK_W-1:0] interest;
      logic [MASK_W-1:0] ready_mask;
      logic [SEQ_W-1:0] read_seq;
      logic [SEQ_W-1:0] write_seq;
      logic [SEQ_W-1:0] claim_tag;
      logic copy_ok;
      logic drain;
   } watch_cmd_type;

   typedef struct packed {
      logic [MASK_W-1:0] report;
      logic [SEQ_W-1:0] claim_tag;
      logic ready_changed;
      status_type status;
   } watch_rsp_type;

   logic clock;
   logic reset = 1'b1;
   logic drv_valid = 1'b0;
   watch_cmd_type drv_cmd = '0;
   logic take_ready = 1'b0;

   // Two copies of the slot table: one steers stimulus planning, one checks responses.
   bit slot_live [2][WATCH_SLOTS];
   watch_entry_type slot_entry [2][WATCH_SLOTS];
   logic [SEQ_W-1:0] claim_count [2] = '{default: '0};

   watch_cmd_type pending_cmds [$];
   watch_rsp_type expected_rsps [$];
   int fail_count = 0;
   int cycle_count = 0;
   int accepted_count = 0;
   int response_count = 0;
   int send_gap = 0;
   int gap_pct = 0;
   int stall_left = 0;
   int stall_pct = 0;

   rets_req_if req_if ();
   rets_rsp_if rsp_if ();

   assign req_if.valid = drv_valid;
   assign req_if.op = drv_cmd.op;
   assign req_if.slot = drv_cmd.slot;
   assign req_if.interest = drv_cmd.interest;
   assign req_if.ready_mask = drv_cmd.ready_mask;
   assign req_if.read_seq = drv_cmd.read_seq;
   assign req_if.write_seq = drv_cmd.write_seq;
   assign req_if.claim_tag_in = drv_cmd.claim_tag;
   assign req_if.copy_ok = drv_cmd.copy_ok;
   assign rsp_if.ready = take_ready;

   readiness_edge_report_table_top uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Applies one transaction to table copy c and returns the response it must produce.
   function automatic watch_rsp_type predict_watch(input int c, input watch_cmd_type cmd);
      watch_rsp_type rsp;
      watch_entry_type ent;
      int s;
      logic [MASK_W-1:0] filt;
      logic [MASK_W-1:0] fresh_bits;
      logic fresh;
      rsp = '0;
      rsp.status = STATUS_OK;
      s = int'(cmd.slot);
      ent = slot_entry[c][s];
      if (cmd.op > OP_FINISH) begin
         rsp.status = STATUS_BAD_OP;
      end else if (cmd.op == OP_ARM) begin
         ent = '0;
         ent.interest = cmd.interest;
         slot_live[c][s] = 1'b1;
      end else if (!slot_live[c][s]) begin
         rsp.status = STATUS_UNUSED;
      end else if (cmd.op == OP_REMOVE) begin
         ent = '0;
         slot_live[c][s] = 1'b0;
      end else if (cmd.op == OP_PREVIEW || cmd.op == OP_CLAIM) begin
         if (!ent.oneshot_off) begin
            filt = cmd.ready_mask & (ent.interest | EV_ERR | EV_HUP);
            fresh = 1'b0;
            if (filt != '0) begin
               if ((filt & ~ent.seen_ready) != '0) fresh = 1'b1;
               if ((filt & READ_GROUP) != '0 && cmd.read_seq != '0 &&
                   cmd.read_seq != ent.seen_read_seq) fresh = 1'b1;
               if ((filt & WRITE_GROUP) != '0 && cmd.write_seq != '0 &&
                   cmd.write_seq != ent.seen_write_seq) fresh = 1'b1;
            end
            ent.seen_ready = filt;
            if ((filt & READ_GROUP) != '0) ent.seen_read_seq = cmd.read_seq;
            if ((filt & WRITE_GROUP) != '0) ent.seen_write_seq = cmd.write_seq;
            if (filt == '0) begin
               ent.delivered_bits = '0;
               ent.delivered_read_seq = '0;
               ent.delivered_write_seq = '0;
               ent.seen_read_seq = '0;
               ent.seen_write_seq = '0;
            end
            rsp.ready_changed = fresh;
            // Edge mode reports only undelivered bits or groups with a new sequence.
            if (filt == '0 || ent.pending_claim != '0) begin
               fresh_bits = '0;
            end else if ((ent.interest & EV_ET) == '0) begin
               fresh_bits = filt;
            end else begin
               fresh_bits = filt & ~ent.delivered_bits;
               if ((filt & READ_GROUP) != '0 && cmd.read_seq != '0 &&
                   cmd.read_seq != ent.delivered_read_seq)
                  fresh_bits |= filt & READ_GROUP;
               if ((filt & WRITE_GROUP) != '0 && cmd.write_seq != '0 &&
                   cmd.write_seq != ent.delivered_write_seq)
                  fresh_bits |= filt & WRITE_GROUP;
            end
            rsp.report = fresh_bits;
            if (cmd.op == OP_CLAIM && fresh_bits != '0 &&
                (ent.interest & (EV_ET | EV_ONESHOT)) != '0) begin
               claim_count[c] = claim_count[c] + 1'b1;
               if (claim_count[c] == '0) claim_count[c] = SEQ_W'(1);
               ent.pending_claim = claim_count[c];
               rsp.claim_tag = claim_count[c];
            end
         end
      end else if (cmd.claim_tag == '0 || cmd.claim_tag != ent.pending_claim) begin
         rsp.status = STATUS_TAG_MISMATCH;
      end else begin
         if (cmd.copy_ok) begin
            if ((ent.interest & EV_ET) != '0) begin
               ent.delivered_bits |= cmd.ready_mask;
               if ((cmd.ready_mask & READ_GROUP) != '0) ent.delivered_read_seq = cmd.read_seq;
               if ((cmd.ready_mask & WRITE_GROUP) != '0)
                  ent.delivered_write_seq = cmd.write_seq;
            end
            if ((ent.interest & EV_ONESHOT) != '0) ent.oneshot_off = 1'b1;
         end
         ent.pending_claim = '0;
      end
      slot_entry[c][s] = ent;
      return rsp;
   endfunction

   task automatic plan_cmd(input logic [OP_W-1:0] op, input int slot,
                           input logic [MASK_W-1:0] interest, input logic [MASK_W-1:0] ready_mask,
                           input logic [SEQ_W-1:0] read_seq, input logic [SEQ_W-1:0] write_seq,
                           input logic [SEQ_W-1:0] claim_tag, input logic copy_ok,
                           input logic drain, output watch_rsp_type rsp);
      watch_cmd_type cmd;
      cmd.op = op;
      cmd.slot = slot[SLOT_W-1:0];
      cmd.interest = interest;
      cmd.ready_mask = ready_mask;
      cmd.read_seq = read_seq;
      cmd.write_seq = write_seq;
      cmd.claim_tag = claim_tag;
      cmd.copy_ok = copy_ok;
      cmd.drain = drain;
      rsp = predict_watch(PLAN, cmd);
      pending_cmds.push_back(cmd);
   endtask

   function automatic logic [SEQ_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [MASK_W-1:0] rand_interest();
      logic [MASK_W-1:0] bits;
      if ($urandom_range(9) == 0) return $urandom;
      bits = $urandom & EVENT_BITS;
      if ($urandom_range(1) == 1) bits |= EV_ET;
      if ($urandom_range(2) == 0) bits |= EV_ONESHOT;
      return bits;
   endfunction

   function automatic logic [MASK_W-1:0] rand_ready();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick < 3) return $urandom;
      return $urandom & EVENT_BITS;
   endfunction

   // Sequences drawn near a running hint so that equal and changed values both occur.
   function automatic logic [SEQ_W-1:0] rand_seq(input logic [SEQ_W-1:0] hint);
      int pick;
      pick = $urandom_range(19);
      if (pick < 5) return '0;
      if (pick < 10) return hint;
      if (pick < 15) return hint + 1'b1;
      if (pick < 18) return rand64();
      return '1;
   endfunction

   // One watch lifetime fragment: optional arm, observations, then an optional finish and remove.
   task automatic plan_sequence(input logic drain);
      int s;
      int n;
      int i;
      int pick;
      logic [SEQ_W-1:0] tag;
      logic [SEQ_W-1:0] rs;
      logic [SEQ_W-1:0] ws;
      logic [MASK_W-1:0] claimed;
      logic [OP_W-1:0] op;
      watch_rsp_type rsp;
      s = ($urandom_range(3) == 0) ? $urandom_range(WATCH_SLOTS - 1) : $urandom_range(7);
      tag = '0;
      claimed = '0;
      rs = rand64();
      ws = rand64();
      if (!slot_live[PLAN][s] || $urandom_range(3) == 0) begin
         plan_cmd(OP_ARM, s, rand_interest(), $urandom, rand64(), rand64(), rand64(),
                  1'($urandom), drain, rsp);
      end else if (drain) begin
         plan_cmd(OP_PREVIEW, s, $urandom, rand_ready(), rs, ws, rand64(), 1'($urandom),
                  drain, rsp);
      end
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         op = ($urandom_range(9) < 6) ? OP_CLAIM : OP_PREVIEW;
         rs = rand_seq(rs);
         ws = rand_seq(ws);
         plan_cmd(op, s, $urandom, rand_ready(), rs, ws, rand64(), 1'($urandom), 1'b0, rsp);
         if (rsp.claim_tag != '0) begin
            tag = rsp.claim_tag;
            claimed = rsp.report;
            if ($urandom_range(1) == 1) break;
         end
      end
      if (tag != '0 || $urandom_range(9) == 0) begin
         pick = $urandom_range(19);
         if (tag == '0 && slot_live[PLAN][s]) tag = slot_entry[PLAN][s].pending_claim;
         if (pick == 0) tag = '0;
         else if (pick == 1) tag = tag + 1'b1;
         else if (pick == 2) tag = rand64();
         if ($urandom_range(3) == 0) claimed = rand_ready();
         plan_cmd(OP_FINISH, s, $urandom, claimed, rs, ws, tag, ($urandom_range(4) != 0),
                  1'b0, rsp);
      end
      if ($urandom_range(9) == 0)
         plan_cmd(OP_REMOVE, s, $urandom, $urandom, rand64(), rand64(), rand64(),
                  1'($urandom), 1'b0, rsp);
   endtask

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   // Driver: presents pending transactions, inserts idle bursts, honors drain points.
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (drv_valid && req_if.ready) begin
            expected_rsps.push_back(predict_watch(CHECK, drv_cmd));
            accepted_count++;
            if (accepted_count % 200 == 0) gap_pct = $urandom_range(2) * 20;
         end
         if (!drv_valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               drv_valid <= 1'b0;
            end else if (pending_cmds.size() == 0 ||
                         (pending_cmds[0].drain && expected_rsps.size() != 0)) begin
               drv_valid <= 1'b0;
            end else begin
               drv_cmd <= pending_cmds.pop_front();
               drv_valid <= 1'b1;
               if (pending_cmds.size() > QUIET_TAIL && $urandom_range(99) < gap_pct)
                  send_gap = $urandom_range(1, 6);
            end
         end
      end
   end

   // Monitor: checks each response transaction and applies receiver stalls.
   always @(posedge clock) begin : monitor
      watch_rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && take_ready) begin
            response_count++;
            if (response_count % 200 == 0) stall_pct = $urandom_range(2) * 20;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response transaction with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_if.report !== want.report)
                  report_mismatch($sformatf("report %h, expected %h", rsp_if.report,
                                            want.report));
               if (rsp_if.claim_tag_out !== want.claim_tag)
                  report_mismatch($sformatf("claim_tag_out %h, expected %h",
                                            rsp_if.claim_tag_out, want.claim_tag));
               if (rsp_if.ready_changed !== want.ready_changed)
                  report_mismatch($sformatf("ready_changed %b, expected %b",
                                            rsp_if.ready_changed, want.ready_changed));
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status,
                                            want.status));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            take_ready <= 1'b0;
         end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            take_ready <= 1'b0;
         end else begin
            take_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** readiness_edge_report_table_top: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      watch_rsp_type rsp;
      logic [SEQ_W-1:0] tag;
      int planned;
      int seq_count;
      // Unused slot, unknown operation.
      plan_cmd(OP_PREVIEW, 5, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_REMOVE, 5, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_CLAIM, 5, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_FINISH, 5, '0, '1, '1, '1, '1, 1'b1, 1'b0, rsp);
      plan_cmd(OP_UNDEFINED, WATCH_SLOTS - 1, '1, '1, '1, '1, '1, 1'b1, 1'b0, rsp);
      // Level-triggered watch.
      plan_cmd(OP_ARM, 0, EV_IN | EV_OUT, '0, '0, '0, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_PREVIEW, 0, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_CLAIM, 0, '0, EV_IN, '0, '0, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_PREVIEW, 0, '0, '0, '0, '0, '0, 1'b0, 1'b0, rsp);
      // Edge-triggered watch: claim, reads while pending, bad tags, commit, new sequence.
      plan_cmd(OP_ARM, WATCH_SLOTS - 1, EV_ET | EV_IN | EV_OUT | EV_RDHUP, '0, '0, '0, '0,
               1'b0, 1'b0, rsp);
      plan_cmd(OP_CLAIM, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, '0, 1'b0, 1'b0, rsp);
      tag = rsp.claim_tag;
      plan_cmd(OP_PREVIEW, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_FINISH, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, '0, 1'b1, 1'b0, rsp);
      plan_cmd(OP_FINISH, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, tag + 1'b1, 1'b1, 1'b0,
               rsp);
      plan_cmd(OP_FINISH, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, tag, 1'b1, 1'b0, rsp);
      plan_cmd(OP_CLAIM, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 1, 1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_CLAIM, WATCH_SLOTS - 1, '0, EV_IN | EV_OUT, 2, 1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_FINISH, WATCH_SLOTS - 1, '0, rsp.report, 2, 1, rsp.claim_tag, 1'b0, 1'b0,
               rsp);
      plan_cmd(OP_CLAIM, WATCH_SLOTS - 1, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      // Re-arm a used slot that holds a claim.
      plan_cmd(OP_ARM, WATCH_SLOTS - 1, '1, '0, '0, '0, '0, 1'b0, 1'b0, rsp);
      // Oneshot watch disabled by a successful finish.
      plan_cmd(OP_ARM, 1, EV_ONESHOT | EV_IN, '0, '0, '0, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_CLAIM, 1, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_FINISH, 1, '0, rsp.report, '1, '1, rsp.claim_tag, 1'b1, 1'b0, rsp);
      plan_cmd(OP_PREVIEW, 1, '0, '1, '1, '1, '0, 1'b0, 1'b0, rsp);
      plan_cmd(OP_REMOVE, WATCH_SLOTS - 1, '0, '0, '0, '0, '0, 1'b0, 1'b0, rsp);
      planned = pending_cmds.size();
      seq_count = 0;
      while (pending_cmds.size() < planned + RANDOM_ITEMS) begin
         if ($urandom_range(4) == 0) begin
            plan_cmd(OP_W'($urandom_range(7)), $urandom_range(WATCH_SLOTS - 1), $urandom,
                     $urandom, rand64(), rand64(), rand64(), 1'($urandom), 1'b0, rsp);
         end else begin
            // Every so often the sender holds off until all responses are back.
            plan_sequence(seq_count % 120 == 0);
            seq_count++;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_cmds.size() != 0 || drv_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("** readiness_edge_report_table_top: PASSED **");
      end else begin
         $display("** readiness_edge_report_table_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rets_pkg.sv
rtl/rets_req_if.sv
rtl/rets_rsp_if.sv
rtl/readiness_edge_report_table_top.sv
rtl/rets_checker.sv
test/readiness_edge_report_table_top_tb.sv
